[sv/sps_pkg.sv]
package sps_pkg;

	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_TICK  = 2'd1;
	localparam logic [1:0] OP_OFF   = 2'd2;

	localparam int DEG_W   = 16;
	localparam int ITER_W  = 17;
	localparam int HOLD_W  = 8;
	localparam int COIL_W  = 4;
	localparam int PHASE_W = 3;

	// floor(deg * 64 / 45) equals (deg * ceil(2^28 / 45)) >> 22 for every 16-bit angle.
	localparam int                 ITER_MUL_W = 23;
	localparam logic [ITER_MUL_W-1:0] ITER_MUL = 23'd5965233;
	localparam int                 ITER_SHIFT = 22;

	localparam logic [PHASE_W-1:0] LAST_WAVE = 3'd3;
	localparam logic [PHASE_W-1:0] LAST_HALF = 3'd7;

	typedef struct packed {
		logic [1:0]        op;
		logic              half_step;
		logic              ccw;
		logic [HOLD_W-1:0] hold_time;
		logic [ITER_W-1:0] iters;
	} item_t;

	function automatic logic [COIL_W-1:0] pattern_at(
		input logic half_step,
		input logic ccw,
		input logic [PHASE_W-1:0] idx
	);
		logic [COIL_W-1:0] pat;
		pat = 4'd0;
		if (half_step) begin
			case ({ccw, idx})
				4'b0_000: pat = 4'd1;
				4'b0_001: pat = 4'd3;
				4'b0_010: pat = 4'd2;
				4'b0_011: pat = 4'd6;
				4'b0_100: pat = 4'd4;
				4'b0_101: pat = 4'd12;
				4'b0_110: pat = 4'd8;
				4'b0_111: pat = 4'd9;
				4'b1_000: pat = 4'd8;
				4'b1_001: pat = 4'd12;
				4'b1_010: pat = 4'd4;
				4'b1_011: pat = 4'd6;
				4'b1_100: pat = 4'd2;
				4'b1_101: pat = 4'd3;
				4'b1_110: pat = 4'd1;
				default:  pat = 4'd9;
			endcase
		end else begin
			case ({ccw, idx[1:0]})
				3'b0_00: pat = 4'd1;
				3'b0_01: pat = 4'd2;
				3'b0_10: pat = 4'd4;
				3'b0_11: pat = 4'd8;
				3'b1_00: pat = 4'd8;
				3'b1_01: pat = 4'd4;
				3'b1_10: pat = 4'd2;
				default: pat = 4'd1;
			endcase
		end
		return pat;
	endfunction

endpackage

[sv/sps_decode.sv]
module sps_decode import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,
	input  logic        advance,
	output logic        item_valid,
	output item_t       item
);

	logic [DEG_W-1:0]            deg;
	logic [HOLD_W-1:0]           ms;
	logic [DEG_W+ITER_MUL_W-1:0] prod;
	logic                        valid_s1;
	item_t                       item_s1;

	assign deg  = s_tdata[27:12];
	assign ms   = s_tdata[11:4];
	assign prod = {{ITER_MUL_W{1'b0}}, deg} * {{DEG_W{1'b0}}, ITER_MUL};

	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op        <= s_tdata[1:0];
			item_s1.half_step <= s_tdata[2];
			item_s1.ccw       <= s_tdata[3];
			item_s1.hold_time <= (ms == '0) ? HOLD_W'(1) : ms;
			item_s1.iters     <= prod[ITER_SHIFT +: ITER_W];
		end
	end

	assign item_valid = valid_s1;
	assign item       = item_s1;

endmodule

[sv/sps_core.sv]
module sps_core import sps_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	input  item_t      item,
	output logic       advance,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata
);

	logic [COIL_W-1:0]  coil_q,       coil_d;
	logic               moving_q,     moving_d;
	logic [PHASE_W-1:0] phase_q,      phase_d;
	logic [HOLD_W-1:0]  hold_left_q,  hold_left_d;
	logic [HOLD_W-1:0]  hold_time_q,  hold_time_d;
	logic [ITER_W-1:0]  iters_left_q, iters_left_d;
	logic               half_q,       half_d;
	logic               ccw_q,        ccw_d;
	logic               done_d, rej_d;
	logic [HOLD_W-1:0]  hold_dec;
	logic [ITER_W-1:0]  iters_dec;
	logic [PHASE_W-1:0] last_idx;
	logic               out_valid_q;
	logic [7:0]         out_data_q;

	assign advance = item_valid && (!out_valid_q || m_tready);

	always_comb begin
		coil_d       = coil_q;
		moving_d     = moving_q;
		phase_d      = phase_q;
		hold_left_d  = hold_left_q;
		hold_time_d  = hold_time_q;
		iters_left_d = iters_left_q;
		half_d       = half_q;
		ccw_d        = ccw_q;
		done_d       = 1'b0;
		rej_d        = 1'b0;
		hold_dec     = (hold_left_q != '0) ? hold_left_q - HOLD_W'(1) : '0;
		iters_dec    = (iters_left_q != '0) ? iters_left_q - ITER_W'(1) : '0;
		last_idx     = half_q ? LAST_HALF : LAST_WAVE;
		case (item.op)
			OP_START: begin
				if (moving_q) begin
					rej_d = 1'b1;
				end else if (item.iters == '0) begin
					done_d = 1'b1;
				end else begin
					half_d       = item.half_step;
					ccw_d        = item.ccw;
					hold_time_d  = item.hold_time;
					hold_left_d  = item.hold_time;
					iters_left_d = item.iters;
					phase_d      = '0;
					coil_d       = pattern_at(item.half_step, item.ccw, '0);
					moving_d     = 1'b1;
				end
			end
			OP_TICK: begin
				if (moving_q) begin
					hold_left_d = hold_dec;
					if (hold_dec == '0) begin
						if (phase_q >= last_idx) begin
							phase_d      = '0;
							iters_left_d = iters_dec;
						end else begin
							phase_d = phase_q + PHASE_W'(1);
						end
						if (phase_q >= last_idx && iters_dec == '0) begin
							moving_d = 1'b0;
							done_d   = 1'b1;
						end else begin
							coil_d      = pattern_at(half_q, ccw_q, phase_d);
							hold_left_d = hold_time_q;
						end
					end
				end
			end
			OP_OFF: begin
				coil_d       = '0;
				moving_d     = 1'b0;
				phase_d      = '0;
				hold_left_d  = '0;
				iters_left_d = '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coil_q       <= '0;
			moving_q     <= 1'b0;
			phase_q      <= '0;
			hold_left_q  <= '0;
			hold_time_q  <= '0;
			iters_left_q <= '0;
			half_q       <= 1'b0;
			ccw_q        <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (advance) begin
				coil_q       <= coil_d;
				moving_q     <= moving_d;
				phase_q      <= phase_d;
				hold_left_q  <= hold_left_d;
				hold_time_q  <= hold_time_d;
				iters_left_q <= iters_left_d;
				half_q       <= half_d;
				ccw_q        <= ccw_d;
				out_valid_q  <= 1'b1;
			end else if (m_tready) begin
				out_valid_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_q <= {1'b0, rej_d, done_d, moving_d, coil_d};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	a_moving_coils: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> coil_q != '0)
		else $error("Coils are off during a move.");

	a_moving_counts: assert property (@(posedge clk) disable iff (!arst_n)
		moving_q |-> (iters_left_q != '0 && hold_left_q != '0 &&
			hold_left_q <= hold_time_q))
		else $error("Move counters are inconsistent.");

	a_wave_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(moving_q && !half_q) |-> phase_q <= LAST_WAVE)
		else $error("Wave step phase out of range.");

	a_reject_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[6]) |-> (out_data_q[4] && !out_data_q[5]))
		else $error("Rejected command reported without a move in progress.");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && done_d) |=> !moving_q)
		else $error("Move reported complete while still moving.");

endmodule

[sv/stepper_phase_sequencer.sv]
// Phase sequencer for a four-coil unipolar stepper. Each input transaction is a move command,
// a one-millisecond tick or a coils-off request, and each yields exactly one output transaction
// carrying the coil drive, the busy flag, a move-complete flag and a rejected flag. A move
// turns floor(degrees*64/45) iterations of four wave phases or eight half-step phases, each
// held for phase_ms ticks (zero counts as one); the last pattern stays on the coils afterwards.
// The block takes one transaction per clock cycle unless the output is back-pressured; the
// iteration count is formed in the input register stage and the state update in the result
// register stage, which then offers the result on the output. Downstream back-pressure holds
// the result register and stalls the input only once both stages are full.
module stepper_phase_sequencer import sps_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// operation[1:0], half_step[2], counter_clockwise[3], phase_ms[11:4], degrees[27:12]
	input  logic [31:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// coils[3:0], busy_res[4], move_done[5], rejected[6]
	output logic [7:0]  m_tdata
);

	logic  item_valid;
	logic  advance;
	item_t item;

	sps_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.advance    (advance),
		.item_valid (item_valid),
		.item       (item)
	);

	sps_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.advance    (advance),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule
